// File: sv/dtso_pkg.sv
// package for the sample-position calendar time block
// types, constants and a helper function shared by all sv/dtso_* files
// no dependencies
package dtso_pkg;

  localparam int MAX_ITEMS   = 512;
  localparam int QUEUE_DEPTH = 4;

  localparam int POS_W  = 10;
  localparam int YEAR_W = 14;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;
  localparam int SEC_W  = 6;
  localparam int SPI_W  = 12;
  localparam int ICNT_W = 10;
  localparam int CFG_W  = 14;
  localparam int IDX_W  = 3;

  // position and count compared in this width
  localparam int WIDE_W = 11;
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int OFF_W  = CNT_W + SPI_W;
  localparam int Q1_W   = OFF_W - 5;
  localparam int Q2_W   = Q1_W - 5;
  localparam int Q3_W   = Q2_W - 4;
  localparam int DAYC_W = (Q3_W > DAY_W + 1) ? Q3_W : DAY_W + 1;

  // reciprocal constants: x/60 = (x>>2)/15, x/24 = (x>>3)/3, y/25
  localparam int DIV15_S  = 26;
  localparam int DIV15_KW = 23;
  localparam logic [DIV15_KW-1:0] DIV15_K = 23'd4473925;
  localparam int DIV3_S  = 12;
  localparam int DIV3_KW = 11;
  localparam logic [DIV3_KW-1:0] DIV3_K = 11'd1366;
  localparam int DIV25_S  = 19;
  localparam int DIV25_KW = 15;
  localparam logic [DIV25_KW-1:0] DIV25_K = 15'd20972;
  localparam int YQ_W = 10;

  localparam int SEC_PER_MIN  = 60;
  localparam int HOUR_PER_DAY = 24;
  localparam int LEAP_DIV     = 25;

  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
  localparam logic [MON_W-1:0]  MON_MAX  = 4'd12;
  localparam logic [HOUR_W-1:0] HOUR_MAX = 5'd23;
  localparam logic [MIN_W-1:0]  MIN_MAX  = 6'd59;
  localparam logic [SEC_W-1:0]  SEC_MAX  = 6'd59;
  localparam logic [SPI_W-1:0]  SPI_MAX  = 12'd3600;

  localparam logic [YEAR_W-1:0] RST_YEAR = 14'd2000;
  localparam logic [ICNT_W-1:0] RST_ICNT = 10'd360;
  localparam logic [SPI_W-1:0]  RST_SPI  = 12'd240;

  typedef enum logic [IDX_W-1:0] {
    REG_NOW_YEAR   = 3'd0,
    REG_NOW_MONTH  = 3'd1,
    REG_NOW_DAY    = 3'd2,
    REG_NOW_HOUR   = 3'd3,
    REG_NOW_MINUTE = 3'd4,
    REG_NOW_SECOND = 3'd5,
    REG_ITEM_COUNT = 3'd6,
    REG_SPI        = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic [CNT_W-1:0]  count;
    logic [SPI_W-1:0]  spi;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic             clamped;
  } q_item_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    len = 5'd31;
    if (m == 4'd2) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end
    return len;
  endfunction

endpackage

// File: sv/dtso_ifs.sv
// stream interfaces for position items and calendar result items
// depends on dtso_pkg
interface dtso_in_if;
  logic                       valid;
  logic                       ready;
  logic [dtso_pkg::POS_W-1:0] position;

  modport source (output valid, output position, input ready);
  modport sink   (input valid, input position, output ready);
endinterface

interface dtso_out_if;
  logic                        valid;
  logic                        ready;
  logic [dtso_pkg::YEAR_W-1:0] out_year;
  logic [dtso_pkg::MON_W-1:0]  out_month;
  logic [dtso_pkg::DAY_W-1:0]  out_day;
  logic [dtso_pkg::HOUR_W-1:0] out_hour;
  logic [dtso_pkg::MIN_W-1:0]  out_minute;
  logic [dtso_pkg::SEC_W-1:0]  out_second;
  logic                        position_clamped;

  modport source (output valid, output out_year, output out_month, output out_day,
                  output out_hour, output out_minute, output out_second,
                  output position_clamped, input ready);
  modport sink   (input valid, input out_year, input out_month, input out_day,
                  input out_hour, input out_minute, input out_second,
                  input position_clamped, output ready);
endinterface

// File: sv/datetime_minus_sample_offset_core.sv
// top level: config registers and saturation, front part, queue, back part
// depends on dtso_pkg, dtso_ifs, dtso_front, dtso_queue, dtso_back
//
// channel   dir   payload                                       handshake
// in_ch     in    position                                      valid/ready
// out_ch    out   out_year .. out_second, position_clamped      valid/ready
// cfg       in    cfg_idx_i, cfg_data_i                         cfg_we_i
//
// one item per cycle while out_ch does not stall; registered in the queue, then in 8 back pipeline stages
// the back pipeline holds as a whole while out_ch stalls; the queue of
// QueueDepth items keeps in_ch accepting until it fills
// reset sets the defaults 2000-01-01 00:00:00, 360 items, 240 s, empties all
module datetime_minus_sample_offset_core #(
  parameter int QueueDepth = dtso_pkg::QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [dtso_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [dtso_pkg::CFG_W-1:0] cfg_data_i,
  dtso_in_if.sink                    in_ch,
  dtso_out_if.source                 out_ch
);

  logic [dtso_pkg::YEAR_W-1:0] now_year_q;
  logic [dtso_pkg::MON_W-1:0]  now_month_q;
  logic [dtso_pkg::DAY_W-1:0]  now_day_q;
  logic [dtso_pkg::HOUR_W-1:0] now_hour_q;
  logic [dtso_pkg::MIN_W-1:0]  now_minute_q;
  logic [dtso_pkg::SEC_W-1:0]  now_second_q;
  logic [dtso_pkg::ICNT_W-1:0] item_count_q;
  logic [dtso_pkg::SPI_W-1:0]  spi_q;

  dtso_pkg::cfg_t    cfg;
  logic              push_valid, push_ready;
  dtso_pkg::q_item_t push_data;
  logic              pop_valid, pop_ready;
  dtso_pkg::q_item_t pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_year_q   <= dtso_pkg::RST_YEAR;
      now_month_q  <= 4'd1;
      now_day_q    <= 5'd1;
      now_hour_q   <= '0;
      now_minute_q <= '0;
      now_second_q <= '0;
      item_count_q <= dtso_pkg::RST_ICNT;
      spi_q        <= dtso_pkg::RST_SPI;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dtso_pkg::REG_NOW_YEAR:   now_year_q   <= cfg_data_i;
        dtso_pkg::REG_NOW_MONTH:  now_month_q  <= cfg_data_i[dtso_pkg::MON_W-1:0];
        dtso_pkg::REG_NOW_DAY:    now_day_q    <= cfg_data_i[dtso_pkg::DAY_W-1:0];
        dtso_pkg::REG_NOW_HOUR:   now_hour_q   <= cfg_data_i[dtso_pkg::HOUR_W-1:0];
        dtso_pkg::REG_NOW_MINUTE: now_minute_q <= cfg_data_i[dtso_pkg::MIN_W-1:0];
        dtso_pkg::REG_NOW_SECOND: now_second_q <= cfg_data_i[dtso_pkg::SEC_W-1:0];
        dtso_pkg::REG_ITEM_COUNT: item_count_q <= cfg_data_i[dtso_pkg::ICNT_W-1:0];
        dtso_pkg::REG_SPI:        spi_q        <= cfg_data_i[dtso_pkg::SPI_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // registers saturated into range
  always_comb begin
    cfg.year   = (now_year_q == '0) ? dtso_pkg::YEAR_W'(1) :
                 (now_year_q > dtso_pkg::YEAR_MAX) ? dtso_pkg::YEAR_MAX : now_year_q;
    cfg.month  = (now_month_q == '0) ? 4'd1 :
                 (now_month_q > dtso_pkg::MON_MAX) ? dtso_pkg::MON_MAX : now_month_q;
    cfg.day    = (now_day_q == '0) ? 5'd1 : now_day_q;
    cfg.hour   = (now_hour_q > dtso_pkg::HOUR_MAX) ? dtso_pkg::HOUR_MAX : now_hour_q;
    cfg.minute = (now_minute_q > dtso_pkg::MIN_MAX) ? dtso_pkg::MIN_MAX : now_minute_q;
    cfg.second = (now_second_q > dtso_pkg::SEC_MAX) ? dtso_pkg::SEC_MAX : now_second_q;
    cfg.spi    = (spi_q > dtso_pkg::SPI_MAX) ? dtso_pkg::SPI_MAX : spi_q;
    if (item_count_q == '0) begin
      cfg.count = dtso_pkg::CNT_W'(1);
    end else if (dtso_pkg::WIDE_W'(item_count_q) >
                 dtso_pkg::WIDE_W'(dtso_pkg::MAX_ITEMS)) begin
      cfg.count = dtso_pkg::CNT_W'(dtso_pkg::MAX_ITEMS);
    end else begin
      cfg.count = dtso_pkg::CNT_W'(item_count_q);
    end
  end

  dtso_front u_front (
    .in_ch        (in_ch),
    .count_i      (cfg.count),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  dtso_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  dtso_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .cfg_i       (cfg),
    .out_ch      (out_ch)
  );

endmodule

// File: sv/dtso_front.sv
// front part: accepts position items, clamps and forms the sample distance
// depends on dtso_pkg and dtso_in_if
module dtso_front (
  dtso_in_if.sink                    in_ch,
  input  logic [dtso_pkg::CNT_W-1:0] count_i,
  output logic                       push_valid_o,
  input  logic                       push_ready_i,
  output dtso_pkg::q_item_t          push_data_o
);

  logic [dtso_pkg::WIDE_W-1:0] pos_w;
  logic [dtso_pkg::WIDE_W-1:0] cnt_w;
  logic                        clamped;

  assign pos_w   = dtso_pkg::WIDE_W'(in_ch.position);
  assign cnt_w   = dtso_pkg::WIDE_W'(count_i);
  assign clamped = (pos_w >= cnt_w);

  assign push_valid_o        = in_ch.valid;
  assign in_ch.ready         = push_ready_i;
  assign push_data_o.clamped = clamped;
  assign push_data_o.n       = clamped ? '0 :
                               dtso_pkg::CNT_W'(cnt_w - pos_w - dtso_pkg::WIDE_W'(1));

endmodule

// File: sv/dtso_queue.sv
// short queue between front and back parts
// depends on dtso_pkg
module dtso_queue #(
  parameter int Depth = dtso_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  dtso_pkg::q_item_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output dtso_pkg::q_item_t pop_data_o
);

  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  dtso_pkg::q_item_t mem_q [Depth];
  logic [AddrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   fill_q, fill_d;
  logic              push, pop;

  assign push_ready_o = (fill_q != CntW'(Depth));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (push && !pop) begin
      fill_d = fill_q + CntW'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: sv/dtso_back.sv
// back part: offset multiply, divide and borrow pipeline, output register
// depends on dtso_pkg and dtso_out_if
module dtso_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  dtso_pkg::q_item_t pop_data_i,
  input  dtso_pkg::cfg_t    cfg_i,
  dtso_out_if.source        out_ch
);

  localparam int Stages = 8;
  localparam int X1W = dtso_pkg::OFF_W - 2;
  localparam int P1W = X1W + dtso_pkg::DIV15_KW;
  localparam int X2W = dtso_pkg::Q1_W - 2;
  localparam int P2W = X2W + dtso_pkg::DIV15_KW;
  localparam int X3W = dtso_pkg::Q2_W - 3;
  localparam int P3W = X3W + dtso_pkg::DIV3_KW;
  localparam int PYW = dtso_pkg::YEAR_W + dtso_pkg::DIV25_KW;
  localparam int YCW = dtso_pkg::YEAR_W + 1;

  typedef struct packed {
    logic [dtso_pkg::OFF_W-1:0] off;
    logic                       clamped;
  } st0_t;

  typedef struct packed {
    logic [dtso_pkg::OFF_W-1:0] off;
    logic [dtso_pkg::Q1_W-1:0]  q1;
    logic                       clamped;
  } st1_t;

  typedef struct packed {
    logic [dtso_pkg::Q1_W-1:0]  q1;
    logic [dtso_pkg::Q2_W-1:0]  q2;
    logic [dtso_pkg::SEC_W-1:0] sec;
    logic                       clamped;
  } st3_t;

  typedef struct packed {
    logic [dtso_pkg::Q2_W-1:0]  q2;
    logic [dtso_pkg::Q3_W-1:0]  q3;
    logic [dtso_pkg::MIN_W-1:0] min;
    logic [dtso_pkg::SEC_W-1:0] sec;
    logic                       clamped;
  } st5_t;

  typedef struct packed {
    logic [dtso_pkg::Q3_W-1:0]   days;
    logic [dtso_pkg::HOUR_W-1:0] hour;
    logic [dtso_pkg::MIN_W-1:0]  min;
    logic [dtso_pkg::SEC_W-1:0]  sec;
    logic                        clamped;
  } st6_t;

  typedef struct packed {
    logic [dtso_pkg::YEAR_W-1:0] year;
    logic [dtso_pkg::MON_W-1:0]  month;
    logic [dtso_pkg::DAY_W-1:0]  day;
    logic [dtso_pkg::HOUR_W-1:0] hour;
    logic [dtso_pkg::MIN_W-1:0]  min;
    logic [dtso_pkg::SEC_W-1:0]  sec;
    logic                        clamped;
  } res_t;

  logic [Stages-1:0] v_q;
  logic              adv;

  st0_t st0_q, st0_d;
  st1_t st1_q, st1_d;
  st3_t st2_q, st2_d;
  st3_t st3_q, st3_d;
  st5_t st4_q, st4_d;
  st5_t st5_q, st5_d;
  st6_t st6_q, st6_d;
  res_t res_q, res_d;

  logic [P1W-1:0] prod1;
  logic [P2W-1:0] prod2;
  logic [P3W-1:0] prod3;
  logic [PYW-1:0] prod_y;

  logic [dtso_pkg::SEC_W-1:0]  r1;
  logic [dtso_pkg::MIN_W-1:0]  r2;
  logic [dtso_pkg::HOUR_W-1:0] r3;

  logic [dtso_pkg::YQ_W-1:0] yq_q;
  logic                      leap_q;
  logic                      leap_d;

  logic [dtso_pkg::MON_W-1:0]  pm;
  logic [dtso_pkg::DAY_W-1:0]  plen;
  logic [dtso_pkg::DAYC_W-1:0] days_c;
  logic [dtso_pkg::DAYC_W-1:0] dy_c;
  logic [dtso_pkg::DAYC_W-1:0] sum_c;

  assign adv         = !v_q[Stages-1] || out_ch.ready;
  assign pop_ready_o = adv;

  // leap flag of the configured year, registered through yq_q and then leap_q
  assign prod_y = PYW'(cfg_i.year) * PYW'(dtso_pkg::DIV25_K);
  assign leap_d = (cfg_i.year[1:0] == 2'b00) &&
                  ((YCW'(yq_q) * YCW'(dtso_pkg::LEAP_DIV) != YCW'(cfg_i.year)) ||
                   (cfg_i.year[3:0] == 4'b0000));

  always_ff @(posedge clk_i) begin
    yq_q   <= prod_y[dtso_pkg::DIV25_S +: dtso_pkg::YQ_W];
    leap_q <= leap_d;
  end

  // seconds offset
  always_comb begin
    st0_d.off     = dtso_pkg::OFF_W'(pop_data_i.n) * dtso_pkg::OFF_W'(cfg_i.spi);
    st0_d.clamped = pop_data_i.clamped;
  end

  // offset / 60
  assign prod1 = P1W'(st0_q.off[dtso_pkg::OFF_W-1:2]) * P1W'(dtso_pkg::DIV15_K);
  always_comb begin
    st1_d.off     = st0_q.off;
    st1_d.q1      = prod1[dtso_pkg::DIV15_S +: dtso_pkg::Q1_W];
    st1_d.clamped = st0_q.clamped;
  end

  // second borrow
  assign r1 = dtso_pkg::SEC_W'(st1_q.off -
                               dtso_pkg::OFF_W'(st1_q.q1) * dtso_pkg::OFF_W'(dtso_pkg::SEC_PER_MIN));
  always_comb begin
    st2_d         = '0;
    st2_d.clamped = st1_q.clamped;
    if (r1 > cfg_i.second) begin
      st2_d.sec = dtso_pkg::SEC_W'(7'(dtso_pkg::SEC_PER_MIN) + 7'(cfg_i.second) - 7'(r1));
      st2_d.q1  = st1_q.q1 + dtso_pkg::Q1_W'(1);
    end else begin
      st2_d.sec = cfg_i.second - r1;
      st2_d.q1  = st1_q.q1;
    end
  end

  // minutes / 60
  assign prod2 = P2W'(st2_q.q1[dtso_pkg::Q1_W-1:2]) * P2W'(dtso_pkg::DIV15_K);
  always_comb begin
    st3_d    = st2_q;
    st3_d.q2 = prod2[dtso_pkg::DIV15_S +: dtso_pkg::Q2_W];
  end

  // minute borrow
  assign r2 = dtso_pkg::MIN_W'(st3_q.q1 -
                               dtso_pkg::Q1_W'(st3_q.q2) * dtso_pkg::Q1_W'(dtso_pkg::SEC_PER_MIN));
  always_comb begin
    st4_d         = '0;
    st4_d.sec     = st3_q.sec;
    st4_d.clamped = st3_q.clamped;
    if (r2 > cfg_i.minute) begin
      st4_d.min = dtso_pkg::MIN_W'(7'(dtso_pkg::SEC_PER_MIN) + 7'(cfg_i.minute) - 7'(r2));
      st4_d.q2  = st3_q.q2 + dtso_pkg::Q2_W'(1);
    end else begin
      st4_d.min = cfg_i.minute - r2;
      st4_d.q2  = st3_q.q2;
    end
  end

  // hours / 24
  assign prod3 = P3W'(st4_q.q2[dtso_pkg::Q2_W-1:3]) * P3W'(dtso_pkg::DIV3_K);
  always_comb begin
    st5_d    = st4_q;
    st5_d.q3 = prod3[dtso_pkg::DIV3_S +: dtso_pkg::Q3_W];
  end

  // hour borrow
  assign r3 = dtso_pkg::HOUR_W'(st5_q.q2 -
                                dtso_pkg::Q2_W'(st5_q.q3) * dtso_pkg::Q2_W'(dtso_pkg::HOUR_PER_DAY));
  always_comb begin
    st6_d.min     = st5_q.min;
    st6_d.sec     = st5_q.sec;
    st6_d.clamped = st5_q.clamped;
    if (r3 > cfg_i.hour) begin
      st6_d.hour = dtso_pkg::HOUR_W'(6'(dtso_pkg::HOUR_PER_DAY) + 6'(cfg_i.hour) - 6'(r3));
      st6_d.days = st5_q.q3 + dtso_pkg::Q3_W'(1);
    end else begin
      st6_d.hour = cfg_i.hour - r3;
      st6_d.days = st5_q.q3;
    end
  end

  // day borrow, at most one month back
  assign pm     = (cfg_i.month == 4'd1) ? dtso_pkg::MON_MAX : cfg_i.month - 4'd1;
  assign plen   = dtso_pkg::month_len(pm, leap_q);
  assign days_c = dtso_pkg::DAYC_W'(st6_q.days);
  assign dy_c   = dtso_pkg::DAYC_W'(cfg_i.day);
  assign sum_c  = dtso_pkg::DAYC_W'(plen) + dy_c;

  always_comb begin
    res_d.year    = cfg_i.year;
    res_d.month   = cfg_i.month;
    res_d.day     = cfg_i.day;
    res_d.hour    = st6_q.hour;
    res_d.min     = st6_q.min;
    res_d.sec     = st6_q.sec;
    res_d.clamped = st6_q.clamped;
    if (days_c != '0) begin
      if (days_c < dy_c) begin
        res_d.day = dtso_pkg::DAY_W'(dy_c - days_c);
      end else begin
        res_d.day   = (sum_c > days_c) ? dtso_pkg::DAY_W'(sum_c - days_c) : 5'd1;
        res_d.month = pm;
        if (cfg_i.month == 4'd1) begin
          res_d.year = cfg_i.year - dtso_pkg::YEAR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[Stages-2:0], pop_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st0_q <= st0_d;
      st1_q <= st1_d;
      st2_q <= st2_d;
      st3_q <= st3_d;
      st4_q <= st4_d;
      st5_q <= st5_d;
      st6_q <= st6_d;
      res_q <= res_d;
    end
  end

  assign out_ch.valid            = v_q[Stages-1];
  assign out_ch.out_year         = res_q.year;
  assign out_ch.out_month        = res_q.month;
  assign out_ch.out_day          = res_q.day;
  assign out_ch.out_hour         = res_q.hour;
  assign out_ch.out_minute       = res_q.min;
  assign out_ch.out_second       = res_q.sec;
  assign out_ch.position_clamped = res_q.clamped;

endmodule
